>>> rtl/core/packet_latency_dedup_tracker_defines.svh
// Assertion macros used by the checker file of the latency tracker.
`ifndef PACKET_LATENCY_DEDUP_TRACKER_DEFINES_SVH
`define PACKET_LATENCY_DEDUP_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/pld_pkg.sv
// Package with the types and constants of the packet latency tracker.
package pld_pkg;

    localparam int TBL_DEPTH = 64;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    typedef struct packed {
        logic        is_sync;
        logic [31:0] pkt_id;
        logic [31:0] tx_time_us;
        logic [31:0] rx_time_us;
    } pkt_t;

    typedef struct packed {
        logic [7:0]         copies;
        logic signed [31:0] raw_lat_us;
        logic signed [31:0] adj_lat_us;
        logic signed [31:0] offset_now;
        logic               offset_known;
    } res_t;

    typedef struct packed {
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        logic [31:0]       wr_id;
        logic [7:0]        wr_count;
    } tbl_req_t;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  count;
        logic        live;
    } tbl_rsp_t;

endpackage

>>> rtl/core/packet_latency_dedup_tracker.sv
// Top level of the packet latency tracker with its duplicate-counting sequencer.
//
// Usage: raise start with a packet on pkt while busy is low; the packet is
// taken at that edge and busy stays high until its result is out. The result
// appears on res, marked by done, which is high for exactly one cycle; the
// receiver cannot stall it and must take it in that cycle.
// Flow: a sync packet, or any packet in connection mode, passes ST_NAIVE
// (rx minus tx time) and ST_CORR (minus the offset), after which its result
// is registered with done. An advertising-mode data packet goes on to scan
// the 64-entry duplicate table through one memory read port, one entry a
// cycle; a match ends the scan early. ST_WRITE then writes the matched entry,
// or a new one at the replacement pointer, and gives the result. Busy falls
// in the cycle that carries done, when the next packet can already be taken.
// The shared subtractor serves each step; one packet is in work at a time.
// The mode register is written over cfg_valid/cfg_ready/cfg_data; the user
// must write it only while idle (not enforced here); cfg_ready is always high.
// Reset clears the offset, its valid flag, the replacement pointer and the
// table's valid bits, and selects connection mode. No clearing pass is needed.
module packet_latency_dedup_tracker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pld_pkg::pkt_t pkt,
    output logic          done,
    output pld_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);
    import pld_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_NAIVE = 3'd1;
    localparam logic [2:0] ST_CORR  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;

    localparam logic [TBL_AW:0]   DEPTH_W  = (TBL_AW + 1)'(TBL_DEPTH);
    localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TBL_DEPTH - 1);

    logic [2:0]        state_reg, state_next;
    pkt_t              pkt_reg, pkt_next;
    logic [31:0]       naive_reg, naive_next;
    logic [31:0]       corr_reg, corr_next;
    logic [31:0]       offset_reg, offset_next;
    logic              offset_valid_reg, offset_valid_next;
    logic              mode_reg, mode_next;
    logic [TBL_AW-1:0] ptr_reg, ptr_next;
    logic [TBL_AW:0]   idx_reg, idx_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [TBL_AW-1:0] rd_idx_reg, rd_idx_next;
    logic [TBL_AW-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]        wr_count_reg, wr_count_next;
    logic              hit_reg, hit_next;
    logic              done_reg, done_next;
    res_t              res_reg, res_next;

    logic [31:0] alu_a, alu_b, alu_diff;
    logic        alu_zero;
    tbl_req_t    tbl_req;
    tbl_rsp_t    tbl_rsp;

    pld_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .zero (alu_zero)
    );

    pld_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rsp   (tbl_rsp)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_NAIVE:
            begin
                alu_a = pkt_reg.rx_time_us;
                alu_b = pkt_reg.tx_time_us;
            end
            ST_CORR:
            begin
                alu_a = naive_reg;
                alu_b = offset_reg;
            end
            default:
            begin
                alu_a = pkt_reg.pkt_id;
                alu_b = tbl_rsp.id;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        pkt_next          = pkt_reg;
        naive_next        = naive_reg;
        corr_next         = corr_reg;
        offset_next       = offset_reg;
        offset_valid_next = offset_valid_reg;
        mode_next         = mode_reg;
        ptr_next          = ptr_reg;
        idx_next          = idx_reg;
        rd_pend_next      = 1'b0;
        rd_idx_next       = rd_idx_reg;
        wr_addr_next      = wr_addr_reg;
        wr_count_next     = wr_count_reg;
        hit_next          = hit_reg;
        done_next         = 1'b0;
        res_next          = res_reg;

        tbl_req.rd_en    = 1'b0;
        tbl_req.rd_addr  = idx_reg[TBL_AW-1:0];
        tbl_req.wr_en    = 1'b0;
        tbl_req.wr_addr  = wr_addr_reg;
        tbl_req.wr_id    = pkt_reg.pkt_id;
        tbl_req.wr_count = wr_count_reg;

        if (cfg_valid)
        begin
            mode_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pkt_next   = pkt;
                    state_next = ST_NAIVE;
                end
            end
            ST_NAIVE:
            begin
                naive_next = alu_diff;
                if (pkt_reg.is_sync)
                begin
                    offset_next       = alu_diff;
                    offset_valid_next = 1'b1;
                end
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                corr_next = offset_valid_reg ? alu_diff : 32'hFFFF_FFFF;
                if (pkt_reg.is_sync || mode_reg)
                begin
                    res_next.copies       = 8'd1;
                    res_next.raw_lat_us   = naive_reg;
                    res_next.adj_lat_us   = corr_next;
                    res_next.offset_now   = offset_reg;
                    res_next.offset_known = offset_valid_reg;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Reads are issued one a cycle; each is compared in the cycle after its read.
                if (idx_reg < DEPTH_W)
                begin
                    tbl_req.rd_en = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                    rd_idx_next   = idx_reg[TBL_AW-1:0];
                end
                if (rd_pend_reg && tbl_rsp.live && alu_zero)
                begin
                    wr_addr_next  = rd_idx_reg;
                    wr_count_next = tbl_rsp.count + 8'd1;
                    hit_next      = 1'b1;
                    state_next    = ST_WRITE;
                end
                else if (rd_pend_reg && (rd_idx_reg == TBL_LAST))
                begin
                    wr_addr_next  = ptr_reg;
                    wr_count_next = 8'd1;
                    hit_next      = 1'b0;
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                tbl_req.wr_en = 1'b1;
                if (!hit_reg)
                begin
                    ptr_next = (ptr_reg == TBL_LAST) ? '0 : ptr_reg + 1'b1;
                end
                res_next.copies       = wr_count_reg;
                res_next.raw_lat_us   = naive_reg;
                res_next.adj_lat_us   = corr_reg;
                res_next.offset_now   = offset_reg;
                res_next.offset_known = offset_valid_reg;
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            offset_reg       <= '0;
            offset_valid_reg <= 1'b0;
            mode_reg         <= 1'b1;
            ptr_reg          <= '0;
            idx_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            hit_reg          <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            offset_reg       <= offset_next;
            offset_valid_reg <= offset_valid_next;
            mode_reg         <= mode_next;
            ptr_reg          <= ptr_next;
            idx_reg          <= idx_next;
            rd_pend_reg      <= rd_pend_next;
            hit_reg          <= hit_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pkt_reg      <= pkt_next;
        naive_reg    <= naive_next;
        corr_reg     <= corr_next;
        rd_idx_reg   <= rd_idx_next;
        wr_addr_reg  <= wr_addr_next;
        wr_count_reg <= wr_count_next;
        res_reg      <= res_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign res       = res_reg;
    assign cfg_ready = 1'b1;
endmodule

>>> rtl/core/pld_alu.sv
// Shared 32-bit subtractor, also used as the equality comparator of the table scan.
module pld_alu (
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] diff,
    output logic        zero
);
    assign diff = a - b;
    assign zero = (diff == 32'd0);
endmodule

>>> rtl/core/pld_table.sv
// Duplicate table: id and count memory with one read and one write port, plus valid bits.
module pld_table (
    input  logic             clk,
    input  logic             rst_n,
    input  pld_pkg::tbl_req_t req,
    output pld_pkg::tbl_rsp_t rsp
);
    import pld_pkg::*;

    logic [39:0]          mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] valid_reg;
    logic [39:0]          rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= {req.wr_id, req.wr_count};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // An entry never written since reset reads as dead, as if cleared to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rsp.id    = rd_data_reg[39:8];
    assign rsp.count = rd_data_reg[7:0];
    assign rsp.live  = rd_valid_reg && (rd_data_reg[7:0] != 8'd0);
endmodule

>>> rtl/core/pld_checker.sv
// Port-level checker for the packet latency tracker, bound to the top level.
`include "packet_latency_dedup_tracker_defines.svh"

module pld_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input pld_pkg::pkt_t pkt,
    input logic          done,
    input pld_pkg::res_t res,
    input logic          cfg_valid,
    input logic          cfg_ready,
    input logic          cfg_data
);
    import pld_pkg::*;

    // An accepted transaction always raises busy in the cycle after it is taken.
    `PLD_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted packet did not raise busy")

    // Done never stays high in back-to-back cycles, so no two packets finish back to back.
    `PLD_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")

    // Without a sync the corrected latency is reported with all bits set (hex FFFF_FFFF).
    `PLD_ASSERT_NOW(a_corr_unknown, done && !res.offset_known, res.adj_lat_us == -32'sd1, "corrected latency not -1 before sync")

    // Only a sync packet can move the offset away from its reset value.
    `PLD_ASSERT_NOW(a_offset_reset, done && !res.offset_known, res.offset_now == 32'sd0, "offset nonzero before any sync")
endmodule

bind packet_latency_dedup_tracker pld_checker u_pld_checker (.*);
